/* hdl/mcc_binary_classifier_score_top_defines.svh */
// assertion macros for the mcc binary classifier scorer
// used by mcc_binary_classifier_score_top, no other dependencies
`ifndef MCC_BINARY_CLASSIFIER_SCORE_TOP_DEFINES_SVH
`define MCC_BINARY_CLASSIFIER_SCORE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcc scorer: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define MCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcc scorer: next-cycle check failed");

`endif

/* hdl/mcc_pkg.sv */
// shared types and constants for the mcc binary classifier scorer
// no dependencies
`default_nettype none

package mcc_pkg;

    // default counter width
    localparam int COUNT_WIDTH_DEF = 32;
    // threshold after reset, 0.5 in q16.16
    localparam logic [31:0] THRESH_RESET = 32'h0000_8000;
    // q2.30 scaling of the squared ratio (2^60)
    localparam int Q_SHIFT = 60;
    // quotient width, quotient never exceeds 2^60
    localparam int QUO_W = 61;
    // integer square root working width and iteration count
    localparam int SQ_W = 62;
    localparam int SQ_ITER = 31;
    // 1.0 in q2.30
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    typedef struct packed {
        logic signed [31:0] prediction_score;
        logic [7:0]         true_label;
        logic               last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] mcc_value;
        logic [31:0]        true_pos_count;
        logic [31:0]        true_neg_count;
        logic [31:0]        false_pos_count;
        logic [31:0]        false_neg_count;
        logic               denominator_zero;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUMS,
        ST_MUL,
        ST_MAG,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_TPTN,
        MUL_FPFN,
        MUL_S12,
        MUL_S34,
        MUL_DEN,
        MUL_NUM
    } t_mul_op;

endpackage

`default_nettype wire

/* hdl/mcc_addsub.sv */
// shared adder/subtractor used by the mcc sequencer
// no dependencies
`default_nettype none

module mcc_addsub #(
    parameter int W = 8
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic         i_sub,
    output logic [W-1:0]      o_sum,
    output logic              o_carry
);

    logic [W-1:0] b_x;

    // a + b, or a - b with carry set when a >= b
    assign b_x = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = (W+1)'(i_a) + (W+1)'(b_x) + (W+1)'(i_sub);

endmodule

`default_nettype wire

/* hdl/mcc_binary_classifier_score_top.sv */
// Matthews correlation scorer for a binary classifier: while idle it counts one scored
// sample per cycle into four saturating confusion counters; on the sample marked last it
// works out the q2.30 coefficient with one shared adder/subtractor and returns one result
// item. An item without the last mark only updates the counters and the input stays ready.
// The work for a last item is six shift-add multiplies, a restoring division one dividend
// bit a cycle and a 31-step integer square root, all on the one adder; the input is not
// ready meanwhile. When fp*fn exceeds tp*tn the magnitude step is retried with the operands
// swapped. When a margin sum is zero the sequencer goes from the sums state straight to the
// last state. A finished result waits in the last state while the output register is still
// full; once it is loaded, the next item is taken while it waits.
// Depends on mcc_pkg, mcc_addsub and mcc_binary_classifier_score_top_defines.svh.
`default_nettype none
`include "mcc_binary_classifier_score_top_defines.svh"

module mcc_binary_classifier_score_top
    import mcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item
);

    localparam int CW    = COUNT_WIDTH;
    localparam int SW    = CW + 1;
    localparam int PW    = 2 * SW;
    localparam int DW    = 4 * SW;
    localparam int MW    = 2 * CW;
    localparam int NW    = 4 * CW + Q_SHIFT;
    localparam int AW    = (DW + 1 > SQ_W) ? DW + 1 : SQ_W;
    localparam int CNT_W = $clog2(NW + 1);

    t_state              r_state, n_state;
    logic [31:0]         r_thr, n_thr;
    logic [CW-1:0]       r_tp, n_tp, r_tn, n_tn, r_fp, n_fp, r_fn, n_fn;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;
    logic [SW-1:0]       r_s1, n_s1, r_s2, n_s2, r_s3, n_s3, r_s4, n_s4;
    logic                r_dz, n_dz;
    logic                r_neg, n_neg;
    logic [MW-1:0]       r_a, n_a, r_b, n_b, r_mag, n_mag;
    logic [PW-1:0]       r_p12, n_p12, r_p34, n_p34;
    logic [DW-1:0]       r_d, n_d, r_rem, n_rem;
    logic [NW-1:0]       r_dvd, n_dvd;
    logic [AW-1:0]       r_acc, n_acc, r_mcand, n_mcand;
    logic [PW-1:0]       r_mplier, n_mplier;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    t_mul_op             r_mop, n_mop;
    logic [SQ_W-1:0]     r_sq_op, n_sq_op, r_sq_res, n_sq_res, r_sq_one, n_sq_one;

    logic                in_acc;
    logic                pred;
    logic [AW-1:0]       alu_a, alu_b, alu_sum;
    logic                alu_sub, alu_carry;
    logic [MW-1:0]       mag_x, mag_y;
    logic signed [31:0]  mcc_mag;

    // the one shared adder/subtractor
    mcc_addsub #(
        .W (AW)
    ) u_addsub (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign in_acc      = i_in_valid & o_in_ready;
    assign pred        = $signed(i_in_item.prediction_score) > $signed(r_thr);
    assign mag_x       = r_neg ? r_b : r_a;
    assign mag_y       = r_neg ? r_a : r_b;
    assign mcc_mag     = r_sq_res[31:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESH_RESET;
            r_tp        <= '0;
            r_tn        <= '0;
            r_fp        <= '0;
            r_fn        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_thr       <= n_thr;
            r_tp        <= n_tp;
            r_tn        <= n_tn;
            r_fp        <= n_fp;
            r_fn        <= n_fn;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_s3       <= n_s3;
        r_s4       <= n_s4;
        r_dz       <= n_dz;
        r_neg      <= n_neg;
        r_a        <= n_a;
        r_b        <= n_b;
        r_mag      <= n_mag;
        r_p12      <= n_p12;
        r_p34      <= n_p34;
        r_d        <= n_d;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_cnt      <= n_cnt;
        r_mop      <= n_mop;
        r_sq_op    <= n_sq_op;
        r_sq_res   <= n_sq_res;
        r_sq_one   <= n_sq_one;
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_thr       = r_thr;
        n_tp        = r_tp;
        n_tn        = r_tn;
        n_fp        = r_fp;
        n_fn        = r_fn;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_s4        = r_s4;
        n_dz        = r_dz;
        n_neg       = r_neg;
        n_a         = r_a;
        n_b         = r_b;
        n_mag       = r_mag;
        n_p12       = r_p12;
        n_p34       = r_p34;
        n_d         = r_d;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_cnt       = r_cnt;
        n_mop       = r_mop;
        n_sq_op     = r_sq_op;
        n_sq_res    = r_sq_res;
        n_sq_one    = r_sq_one;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // threshold write
        if (i_cfg_we) begin
            n_thr = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // saturating confusion counters
                    if (i_in_item.true_label == 8'd1) begin
                        if (pred) begin
                            if (r_tp != {CW{1'b1}}) n_tp = r_tp + CW'(1);
                        end else begin
                            if (r_fn != {CW{1'b1}}) n_fn = r_fn + CW'(1);
                        end
                    end else if (i_in_item.true_label == 8'd0) begin
                        if (pred) begin
                            if (r_fp != {CW{1'b1}}) n_fp = r_fp + CW'(1);
                        end else begin
                            if (r_tn != {CW{1'b1}}) n_tn = r_tn + CW'(1);
                        end
                    end
                    if (i_in_item.last_sample) begin
                        n_state = ST_SUMS;
                    end
                end
            end
            ST_SUMS: begin
                // margin sums and the zero check
                n_s1     = SW'(r_tp) + SW'(r_fp);
                n_s2     = SW'(r_tp) + SW'(r_fn);
                n_s3     = SW'(r_tn) + SW'(r_fp);
                n_s4     = SW'(r_tn) + SW'(r_fn);
                n_neg    = 1'b0;
                n_sq_res = '0;
                n_dz     = (n_s1 == '0) || (n_s2 == '0) || (n_s3 == '0) || (n_s4 == '0);
                if (n_dz) begin
                    n_state = ST_DONE;
                end else begin
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = AW'(r_tp);
                    n_mplier = PW'(r_tn);
                    n_mop    = MUL_TPTN;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                // one shift-add step
                alu_a    = r_acc;
                alu_b    = r_mcand;
                alu_sub  = 1'b0;
                n_acc    = r_mplier[0] ? alu_sum : r_acc;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PW - 1)) begin
                    n_cnt = '0;
                    case (r_mop)
                        MUL_TPTN: begin
                            n_a      = n_acc[MW-1:0];
                            n_acc    = '0;
                            n_mcand  = AW'(r_fp);
                            n_mplier = PW'(r_fn);
                            n_mop    = MUL_FPFN;
                        end
                        MUL_FPFN: begin
                            n_b     = n_acc[MW-1:0];
                            n_state = ST_MAG;
                        end
                        MUL_S12: begin
                            n_p12    = n_acc[PW-1:0];
                            n_acc    = '0;
                            n_mcand  = AW'(r_s3);
                            n_mplier = PW'(r_s4);
                            n_mop    = MUL_S34;
                        end
                        MUL_S34: begin
                            n_p34    = n_acc[PW-1:0];
                            n_mcand  = AW'(r_p12);
                            n_mplier = n_acc[PW-1:0];
                            n_acc    = '0;
                            n_mop    = MUL_DEN;
                        end
                        MUL_DEN: begin
                            n_d      = n_acc[DW-1:0];
                            n_acc    = '0;
                            n_mcand  = AW'(r_mag);
                            n_mplier = PW'(r_mag);
                            n_mop    = MUL_NUM;
                        end
                        MUL_NUM: begin
                            n_dvd   = {n_acc[2*MW-1:0], {Q_SHIFT{1'b0}}};
                            n_rem   = '0;
                            n_state = ST_DIV;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MAG: begin
                // |tp*tn - fp*fn|, retried with operands swapped on a borrow
                alu_a   = AW'(mag_x);
                alu_b   = AW'(mag_y);
                alu_sub = 1'b1;
                if (alu_carry) begin
                    n_mag    = alu_sum[MW-1:0];
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_mcand  = AW'(r_s1);
                    n_mplier = PW'(r_s2);
                    n_mop    = MUL_S12;
                    n_state  = ST_MUL;
                end else begin
                    n_neg = 1'b1;
                end
            end
            ST_DIV: begin
                // restoring division, one dividend bit per cycle
                alu_a   = AW'({r_rem, r_dvd[NW-1]});
                alu_b   = AW'(r_d);
                alu_sub = 1'b1;
                if (alu_carry) begin
                    n_rem = alu_sum[DW-1:0];
                end else begin
                    n_rem = {r_rem[DW-2:0], r_dvd[NW-1]};
                end
                n_dvd = {r_dvd[NW-2:0], alu_carry};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    n_cnt    = '0;
                    n_sq_op  = SQ_W'(n_dvd[QUO_W-1:0]);
                    n_sq_res = '0;
                    n_sq_one = SQ_W'(1) << (2 * (SQ_ITER - 1));
                    n_state  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // digit-by-digit integer square root
                alu_a   = AW'(r_sq_op);
                alu_b   = AW'(r_sq_res | r_sq_one);
                alu_sub = 1'b1;
                if (alu_carry) begin
                    n_sq_op  = alu_sum[SQ_W-1:0];
                    n_sq_res = (r_sq_res >> 1) | r_sq_one;
                end else begin
                    n_sq_res = r_sq_res >> 1;
                end
                n_sq_one = r_sq_one >> 2;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQ_ITER - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand over the result once the output register is free
                if (!n_out_valid) begin
                    n_out_valid                 = 1'b1;
                    n_out_item.mcc_value        = r_neg ? -mcc_mag : mcc_mag;
                    n_out_item.true_pos_count   = 32'(r_tp);
                    n_out_item.true_neg_count   = 32'(r_tn);
                    n_out_item.false_pos_count  = 32'(r_fp);
                    n_out_item.false_neg_count  = 32'(r_fn);
                    n_out_item.denominator_zero = r_dz;
                    n_tp                        = '0;
                    n_tn                        = '0;
                    n_fp                        = '0;
                    n_fn                        = '0;
                    n_state                     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // checks
    `MCC_ASSERT_NXT(a_last_starts, i_clk, i_rst_n, in_acc && i_in_item.last_sample, r_state == ST_SUMS)
    `MCC_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, r_out_valid && r_out_item.denominator_zero, r_out_item.mcc_value == 32'sd0)
    `MCC_ASSERT_IMP(a_mcc_range, i_clk, i_rst_n, r_out_valid, (r_out_item.mcc_value <= ONE_Q30) && (r_out_item.mcc_value >= -ONE_Q30))

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for mcc_binary_classifier_score_top
// depends on mcc_pkg and the scorer rtl; predicts each batch result and compares it
`default_nettype none

module tb_top;
    import mcc_pkg::*;

    localparam int CNT_W = 32;
    localparam longint CNT_MAX = (64'd1 << CNT_W) - 1;
    localparam int RAND_ITEMS = 1250;
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int DRAIN_CYCLES = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;

    mcc_binary_classifier_score_top #(.COUNT_WIDTH(CNT_W)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] thresh_q16;
    longint unsigned tp_cnt, tn_cnt, fp_cnt, fn_cnt;
    t_out_item batch_results[$];
    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    bit  idle_free = 1'b0;

    // directed table row; check_known marks rows whose result is typed in
    typedef struct {
        logic signed [31:0] score;
        logic [7:0]         label;
        logic               last;
        bit                 check_known;
        t_out_item          known;
    } t_row;

    function automatic longint unsigned sat_bump(longint unsigned c);
        return (c >= CNT_MAX) ? CNT_MAX : c + 1;
    endfunction

    // q2.30 coefficient by bitwise integer root search on wide products
    function automatic t_out_item score_batch();
        t_out_item r;
        logic [63:0] s1, s2, s3, s4, pa, pb, mag;
        logic [255:0] den, num, lhs, cand;
        logic [31:0] m;
        bit neg;
        r = '0;
        r.true_pos_count  = tp_cnt[31:0];
        r.true_neg_count  = tn_cnt[31:0];
        r.false_pos_count = fp_cnt[31:0];
        r.false_neg_count = fn_cnt[31:0];
        s1 = tp_cnt + fp_cnt; s2 = tp_cnt + fn_cnt;
        s3 = tn_cnt + fp_cnt; s4 = tn_cnt + fn_cnt;
        if (s1 == 0 || s2 == 0 || s3 == 0 || s4 == 0) begin
            r.denominator_zero = 1'b1;
            r.mcc_value = '0;
            return r;
        end
        pa = tp_cnt * tn_cnt;
        pb = fp_cnt * fn_cnt;
        neg = pb > pa;
        mag = neg ? pb - pa : pa - pb;
        den = 256'(s1) * 256'(s2) * 256'(s3) * 256'(s4);
        num = (256'(mag) * 256'(mag)) << 60;
        m = '0;
        for (int b = 30; b >= 0; b--) begin
            cand = 256'(m | (32'd1 << b));
            lhs = cand * cand * den;
            if (lhs <= num) m = m | (32'd1 << b);
        end
        r.mcc_value = neg ? -m : m;
        return r;
    endfunction

    // count one accepted item, queue a result on the last mark
    task automatic count_sample(input t_in_item it);
        bit pos;
        pos = it.prediction_score > thresh_q16;
        if (it.true_label == 8'd1) begin
            if (pos) tp_cnt = sat_bump(tp_cnt); else fn_cnt = sat_bump(fn_cnt);
        end else if (it.true_label == 8'd0) begin
            if (pos) fp_cnt = sat_bump(fp_cnt); else tn_cnt = sat_bump(tn_cnt);
        end
        if (it.last_sample) begin
            batch_results = {batch_results, score_batch()};
            tp_cnt = 0; tn_cnt = 0; fp_cnt = 0; fn_cnt = 0;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (batch_results.size() == 0) begin
                $error("unexpected result item");
                fail_cnt++;
            end else begin
                exp_item = batch_results.pop_front();
                if (o_out_item.mcc_value !== exp_item.mcc_value) begin
                    $error("mcc_value exp %0d got %0d", exp_item.mcc_value, o_out_item.mcc_value);
                    fail_cnt++;
                end
                if (o_out_item.true_pos_count !== exp_item.true_pos_count) begin
                    $error("true_pos_count exp %0d got %0d",
                           exp_item.true_pos_count, o_out_item.true_pos_count);
                    fail_cnt++;
                end
                if (o_out_item.true_neg_count !== exp_item.true_neg_count) begin
                    $error("true_neg_count exp %0d got %0d",
                           exp_item.true_neg_count, o_out_item.true_neg_count);
                    fail_cnt++;
                end
                if (o_out_item.false_pos_count !== exp_item.false_pos_count) begin
                    $error("false_pos_count exp %0d got %0d",
                           exp_item.false_pos_count, o_out_item.false_pos_count);
                    fail_cnt++;
                end
                if (o_out_item.false_neg_count !== exp_item.false_neg_count) begin
                    $error("false_neg_count exp %0d got %0d",
                           exp_item.false_neg_count, o_out_item.false_neg_count);
                    fail_cnt++;
                end
                if (o_out_item.denominator_zero !== exp_item.denominator_zero) begin
                    $error("denominator_zero exp %0b got %0b",
                           exp_item.denominator_zero, o_out_item.denominator_zero);
                    fail_cnt++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= TIMEOUT_CYCLES) begin
            $display("mcc_binary_classifier_score_top: mismatch");
            $finish;
        end
    end

    // send one item, holding valid until accepted; valid stays up for the next item
    task automatic send_item(input t_in_item it);
        if (!idle_free) begin
            while ($urandom_range(99) < 8) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        count_sample(it);
        @(negedge i_clk);
    endtask

    // stop sending and wait for all results
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (batch_results.size() != 0) @(negedge i_clk);
    endtask

    // wait for all results, then for the block to go quiet
    task automatic drain_results();
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_thresh(input logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        thresh_q16 = v;
    endtask

    // random batch: mostly small labels 0/1, some noise labels
    task automatic random_batch(input int len);
        t_in_item it;
        for (int k = 0; k < len; k++) begin
            it.prediction_score = ($urandom_range(3) == 0) ? $urandom()
                                : $signed(32'(int'($urandom_range(131072)) - 65536));
            it.true_label = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(1));
            it.last_sample = (k == len - 1);
            send_item(it);
        end
    endtask

    t_row dir_rows[$];
    t_in_item it;
    t_out_item z;
    t_out_item z_tn;
    int sent;
    int blen;

    initial begin
        tp_cnt = 0; tn_cnt = 0; fp_cnt = 0; fn_cnt = 0;
        thresh_q16 = THRESH_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows: empty batch, extremes, other labels, all four cells
        z = '0; z.denominator_zero = 1'b1;
        z_tn = z; z_tn.true_neg_count = 32'd1;
        dir_rows = {dir_rows, t_row'{32'sh0, 8'd0, 1'b1, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh0, 8'd0, 1'b1, 1'b1, z_tn}};
        dir_rows = {dir_rows, t_row'{32'sh8000_0000, 8'd255, 1'b1, 1'b1, z}};
        dir_rows = {dir_rows, t_row'{32'sh7FFF_FFFF, 8'd2, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh7FFF_FFFF, 8'd1, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh8000_0000, 8'd0, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh0000_8000, 8'd1, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh0000_8001, 8'd0, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh0001_0000, 8'd1, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh0000_0000, 8'd0, 1'b1, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh7FFF_FFFF, 8'd1, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh8000_0000, 8'd0, 1'b1, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh7FFF_FFFF, 8'd0, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh8000_0000, 8'd1, 1'b1, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'sh0000_5555, 8'd170, 1'b0, 1'b0, z}};
        dir_rows = {dir_rows, t_row'{32'shAAAA_AAAA, 8'd85, 1'b1, 1'b0, z}};
        foreach (dir_rows[i]) begin
            it.prediction_score = dir_rows[i].score;
            it.true_label = dir_rows[i].label;
            it.last_sample = dir_rows[i].last;
            send_item(it);
            if (dir_rows[i].check_known) batch_results[$] = dir_rows[i].known;
        end
        drain_results();

        // threshold extremes and random settings, random batches per phase
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_thresh(32'h8000_0000);
                1: write_thresh(32'h7FFF_FFFF);
                2: write_thresh(32'h0000_0000);
                default: write_thresh(32'(int'($urandom_range(65536)) - 32768));
            endcase
            idle_free = (ph == 3);
            while (sent < (ph + 1) * RAND_ITEMS / 6) begin
                blen = $urandom_range(40, 1);
                random_batch(blen);
                sent = sent + blen;
            end
            drain_results();
        end
        // restore reset value, short tail with the sender paused mid-way
        write_thresh(THRESH_RESET);
        random_batch(8);
        wait_results();
        random_batch(8);
        drain_results();

        if (fail_cnt == 0) begin
            $display("mcc_binary_classifier_score_top: match");
        end else begin
            $display("mcc_binary_classifier_score_top: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
